// ===== rtl/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps

package wsd_pkg;

  localparam logic [31:0] LEN_LIMIT_RST = 32'd16777216;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_flag;
    logic [31:0] frame_length;
    logic        last_of_frame;
  } res_t;

endpackage

// ===== rtl/wsd_parser.sv =====
// frame header parser, length check and payload unmasking, one byte per beat
`timescale 1ns / 1ps

module wsd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          beat,
  input  logic [7:0]    data_byte,
  input  logic [31:0]   len_limit,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_ERROR   = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [31:0] len_r, len_nxt;
  logic        big_r, big_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  mask_left_r, mask_left_nxt;
  logic [31:0] pay_left_r, pay_left_nxt;
  logic [1:0]  lane_r, lane_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;

  logic        check;
  logic        bad;
  logic [7:0]  key_byte;

  always_comb begin
    case (lane_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // length is known when check is high: any bit above 32 means too long
  assign bad = big_nxt || (len_nxt > len_limit) || !masked_nxt;

  always_comb begin
    phase_nxt     = phase_r;
    ext_left_nxt  = ext_left_r;
    len_nxt       = len_r;
    big_nxt       = big_r;
    key_nxt       = key_r;
    mask_left_nxt = mask_left_r;
    pay_left_nxt  = pay_left_r;
    lane_nxt      = lane_r;
    fin_nxt       = fin_r;
    opcode_nxt    = opcode_r;
    masked_nxt    = masked_r;
    check         = 1'b0;

    res               = '0;
    res.frame_opcode  = opcode_r;
    res.final_flag    = fin_r;
    res.frame_length  = len_r;

    case (phase_r)
      PH_HDR0: begin
        fin_nxt    = data_byte[7];
        opcode_nxt = data_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = data_byte[7];
        big_nxt    = 1'b0;
        len_nxt    = '0;
        if (data_byte[6:0] == LEN_EXT16) begin
          ext_left_nxt = 4'd2;
          phase_nxt    = PH_EXTLEN;
        end else if (data_byte[6:0] == LEN_EXT64) begin
          ext_left_nxt = 4'd8;
          phase_nxt    = PH_EXTLEN;
        end else begin
          len_nxt = {25'd0, data_byte[6:0]};
          check   = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_nxt      = {len_r[23:0], data_byte};
        big_nxt      = big_r || (len_r[31:24] != 8'd0);
        ext_left_nxt = ext_left_r - 4'd1;
        check        = (ext_left_nxt == 4'd0);
      end
      PH_MASK: begin
        key_nxt       = {key_r[23:0], data_byte};
        mask_left_nxt = mask_left_r - 3'd1;
        if (mask_left_nxt == 3'd0) begin
          lane_nxt = 2'd0;
          if (pay_left_r == 32'd0) begin
            phase_nxt         = PH_HDR0;
            res.valid         = 1'b1;
            res.kind          = KIND_EMPTY;
            res.last_of_frame = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        lane_nxt          = lane_r + 2'd1;
        pay_left_nxt      = pay_left_r - 32'd1;
        res.valid         = 1'b1;
        res.kind          = KIND_DATA;
        res.payload_byte  = data_byte ^ key_byte;
        res.last_of_frame = (pay_left_nxt == 32'd0);
        if (pay_left_nxt == 32'd0) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
      end
    endcase

    if (check) begin
      if (bad) begin
        phase_nxt         = PH_ERROR;
        res.valid         = 1'b1;
        res.kind          = KIND_ERROR;
        res.last_of_frame = 1'b1;
        res.frame_length  = big_nxt ? 32'hffff_ffff : len_nxt;
      end else begin
        pay_left_nxt  = len_nxt;
        key_nxt       = '0;
        mask_left_nxt = 3'd4;
        phase_nxt     = PH_MASK;
      end
    end

    res.valid = res.valid && beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      ext_left_r  <= '0;
      len_r       <= '0;
      big_r       <= 1'b0;
      key_r       <= '0;
      mask_left_r <= '0;
      pay_left_r  <= '0;
      lane_r      <= '0;
      fin_r       <= 1'b0;
      opcode_r    <= '0;
      masked_r    <= 1'b0;
    end else if (beat) begin
      phase_r     <= phase_nxt;
      ext_left_r  <= ext_left_nxt;
      len_r       <= len_nxt;
      big_r       <= big_nxt;
      key_r       <= key_nxt;
      mask_left_r <= mask_left_nxt;
      pay_left_r  <= pay_left_nxt;
      lane_r      <= lane_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      masked_r    <= masked_nxt;
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
//
//   port group | dir | beat content
//   in_*       | in  | one raw byte of the frame stream
//   out_*      | out | payload byte, empty frame marker or protocol error
//   cfg_*      | in  | payload length limit register write
//
// one input beat per cycle while in_stall is low; a result appears in
// the output register the cycle after the byte that causes it
// the output register takes a new result while the old one is being taken,
// so input stalls only while a held result is itself stalled
// reset is synchronous and active low; the length limit resets to 16777216
// after a protocol error all bytes are dropped until reset
`timescale 1ns / 1ps

module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_final_flag,
  output logic [31:0] out_frame_length,
  output logic        out_last_of_frame,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import wsd_pkg::*;

  logic [31:0] len_limit_r;
  logic        beat;
  res_t        res;
  res_t        out_r;

  assign in_stall = out_r.valid && out_stall;
  assign beat     = in_valid && !in_stall;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .data_byte (in_data_byte),
    .len_limit (len_limit_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_limit_r <= LEN_LIMIT_RST;
    end else if (cfg_wr_en) begin
      len_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (!in_stall) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_r.valid;
  assign out_kind          = out_r.kind;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_frame_opcode  = out_r.frame_opcode;
  assign out_final_flag    = out_r.final_flag;
  assign out_frame_length  = out_r.frame_length;
  assign out_last_of_frame = out_r.last_of_frame;

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the websocket frame deframer
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  localparam int ENC7 = 0;
  localparam int ENC16 = 1;
  localparam int ENC64 = 2;
  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;
  localparam int QUIET_LIMIT = 3000;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_EXTLEN, ST_MASK, ST_PAYLOAD, ST_ERROR
  } parse_st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic [31:0] length;
    logic        last;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [3:0]  out_frame_opcode;
  logic        out_final_flag;
  logic [31:0] out_frame_length;
  logic        out_last_of_frame;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  logic [7:0]  stream_q[$];
  deframed_t   deframed_q[$];
  int unsigned n_queued = 0;
  int unsigned beats_in = 0;
  int unsigned results_out = 0;
  int unsigned n_err = 0;
  int unsigned quiet = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  wire         calm = (beats_in >= 700) && (beats_in < 1000);

  // predictor state
  logic [31:0] max_len = LEN_LIMIT_RST;
  parse_st_t   st = ST_HDR0;
  logic [3:0]  ext_left = '0;
  logic [63:0] decl_len = '0;
  logic [31:0] key = '0;
  logic [2:0]  key_left = '0;
  logic [31:0] bytes_left = '0;
  logic [1:0]  lane = '0;
  logic        fin_bit = 1'b0;
  logic [3:0]  op_nib = '0;
  logic        mask_bit = 1'b0;

  websocket_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_final_flag   (out_final_flag),
    .out_frame_length (out_frame_length),
    .out_last_of_frame(out_last_of_frame),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void emit(logic [1:0] k, logic [7:0] d, logic lst);
    deframed_t r;
    r.kind = k;
    r.data = d;
    r.opcode = op_nib;
    r.fin = fin_bit;
    r.length = (decl_len[63:32] != 32'h0) ? 32'hffff_ffff : decl_len[31:0];
    r.last = lst;
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic void length_done();
    if (decl_len[63] || decl_len > {32'h0, max_len} || !mask_bit) begin
      st = ST_ERROR;
      emit(KIND_ERROR, 8'h00, 1'b1);
    end else begin
      bytes_left = decl_len[31:0];
      key = '0;
      key_left = 3'd4;
      st = ST_MASK;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] kb;
    case (st)
      ST_HDR0: begin
        fin_bit = b[7];
        op_nib = b[3:0];
        st = ST_HDR1;
      end
      ST_HDR1: begin
        mask_bit = b[7];
        decl_len = '0;
        if (b[6:0] == LEN_CODE16) begin
          ext_left = 4'd2;
          st = ST_EXTLEN;
        end else if (b[6:0] == LEN_CODE64) begin
          ext_left = 4'd8;
          st = ST_EXTLEN;
        end else begin
          decl_len = {57'h0, b[6:0]};
          length_done();
        end
      end
      ST_EXTLEN: begin
        decl_len = {decl_len[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) length_done();
      end
      ST_MASK: begin
        key = {key[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) begin
          lane = '0;
          if (bytes_left == 32'd0) begin
            st = ST_HDR0;
            emit(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            st = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        kb = key[8 * (3 - lane) +: 8];
        lane = lane + 2'd1;
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) st = ST_HDR0;
        emit(KIND_DATA, b ^ kb, bytes_left == 32'd0);
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (n_err < 100) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_err++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte);
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          in_data_byte <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    deframed_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_out <= results_out + 1;
        if (deframed_q.size() == 0) begin
          if (n_err < 100) $error("unexpected beat: kind %0d", out_kind);
          n_err++;
        end else begin
          want = deframed_q.pop_front();
          compare_field("kind", 32'(want.kind), 32'(out_kind));
          compare_field("payload_byte", 32'(want.data), 32'(out_payload_byte));
          compare_field("frame_opcode", 32'(want.opcode), 32'(out_frame_opcode));
          compare_field("final_flag", 32'(want.fin), 32'(out_final_flag));
          compare_field("frame_length", want.length, out_frame_length);
          compare_field("last_of_frame", 32'(want.last), 32'(out_last_of_frame));
        end
      end
      // long hold-off once, so the block backs up into its input
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_out >= 250) begin
        out_stall <= 1'b1;
        hold_left <= 150;
        hold_done <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic void put(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
    n_queued++;
  endfunction

  function automatic void push_header(logic [7:0] b0, logic mbit, logic [63:0] len, int enc);
    put(b0);
    case (enc)
      ENC7: put({mbit, len[6:0]});
      ENC16: begin
        put({mbit, LEN_CODE16});
        put(len[15:8]);
        put(len[7:0]);
      end
      default: begin
        put({mbit, LEN_CODE64});
        for (int i = 7; i >= 0; i--) put(len[8 * i +: 8]);
      end
    endcase
  endfunction

  function automatic void push_frame(logic [7:0] b0, int unsigned len, int enc);
    logic [31:0] mkey;
    mkey = $urandom;
    push_header(b0, 1'b1, {32'h0, len}, enc);
    for (int i = 3; i >= 0; i--) put(mkey[8 * i +: 8]);
    for (int unsigned i = 0; i < len; i++) put(8'($urandom));
  endfunction

  function automatic void push_rand_frame(logic [31:0] cap);
    int unsigned hi;
    int unsigned len;
    int unsigned roll;
    int enc;
    roll = $urandom_range(0, 99);
    hi = (roll < 70) ? 12 : ((roll < 92) ? 125 : 300);
    if (cap < hi) hi = cap;
    len = $urandom_range(0, hi);
    roll = $urandom_range(0, 99);
    if (len < 126 && roll < 70) enc = ENC7;
    else if (roll < 90) enc = ENC16;
    else enc = ENC64;
    push_frame(8'($urandom), len, enc);
  endfunction

  task automatic fill(logic [31:0] cap, int unsigned n);
    int unsigned goal;
    goal = n_queued + n;
    while (n_queued < goal) push_rand_frame(cap);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_valid || deframed_q.size() != 0);
  endtask

  task automatic set_len_limit(logic [31:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    max_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one terminal violation; afterwards every byte is dropped
  task automatic push_violation();
    case ($urandom_range(0, 2))
      0: push_header(8'($urandom), 1'b1, {1'b1, 31'($urandom), 32'($urandom)}, ENC64);
      1: push_header(8'($urandom), 1'b1,
                     {32'h0, max_len} + 64'd1 + 64'($urandom_range(0, 3)), ENC64);
      default: push_header(8'($urandom), 1'b0, 64'($urandom_range(0, 125)),
                           $urandom_range(ENC7, ENC64));
    endcase
    for (int i = 0; i < 20; i++) put(8'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    push_frame(8'hff, 1, ENC16);
    push_frame(8'h00, 0, ENC64);
    fill(max_len, 380);
    set_len_limit(32'h0);
    fill(max_len, 60);
    set_len_limit(32'hffff_ffff);
    push_frame(8'($urandom), 130, ENC64);
    fill(max_len, 350);
    set_len_limit($urandom_range(1, 40));
    push_frame(8'($urandom), max_len, ENC16);
    fill(max_len, 350);
    set_len_limit($urandom);
    fill(max_len, 300);
    push_violation();
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
